@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHAF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHAF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/chaf_pkg.sv @@
// ----------------------------------------------------------------------------
// chaf_pkg
// Shared types, constants and the arctangent table for the compass filter.
// ----------------------------------------------------------------------------
package chaf_pkg;

  // Heading units: 1/64 degree
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int FAST_LIMIT   = 320;
  localparam int MEDIUM_LIMIT = 128;
  // CORDIC angle units: 1/16384 degree
  localparam int QUARTER_FINE = 1474560;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);

  // Norm threshold: 100*s < 121<<28  <=>  s < ceil(121*2^28/100)
  localparam longint NEAR_LIMIT = ((longint'(121) << 28) + 99) / 100;

  // Register reset values
  localparam logic [15:0] X_SCALE_RST   = 16'd16384;
  localparam logic [15:0] Y_SCALE_RST   = 16'd16384;
  localparam logic [15:0] ALPHA_F_RST   = 16'd32768;
  localparam logic [15:0] ALPHA_M_RST   = 16'd49152;
  localparam logic [15:0] ALPHA_S_RST   = 16'd58982;

  typedef enum logic [3:0] {
    CFG_X_OFFSET     = 4'd0,
    CFG_Y_OFFSET     = 4'd1,
    CFG_X_SCALE      = 4'd2,
    CFG_Y_SCALE      = 4'd3,
    CFG_MOUNT_ANGLE  = 4'd4,
    CFG_ALPHA_FAST   = 4'd5,
    CFG_ALPHA_MEDIUM = 4'd6,
    CFG_ALPHA_SLOW   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic               read_ok;
  } sample_t;

  typedef struct packed {
    logic [14:0] heading;
    logic        held;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic [15:0]        x_scale;
    logic [15:0]        y_scale;
    logic [14:0]        mount_angle;
    logic [15:0]        alpha_fast;
    logic [15:0]        alpha_medium;
    logic [15:0]        alpha_slow;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MULX,
    OP_MULY,
    OP_SQX,
    OP_SQY,
    OP_TEST,
    OP_STEP,
    OP_MAP,
    OP_MOUNT,
    OP_DIFF,
    OP_AMUL,
    OP_UPDATE,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic hold;
  } status_t;

  // atan(2^-i) in 1/16384 degree, rounded to nearest
  function automatic logic [19:0] atan_lut(input logic [4:0] idx);
    logic [19:0] v;
    case (idx)
      5'd0:  v = 20'd737280;
      5'd1:  v = 20'd435242;
      5'd2:  v = 20'd229970;
      5'd3:  v = 20'd116736;
      5'd4:  v = 20'd58595;
      5'd5:  v = 20'd29326;
      5'd6:  v = 20'd14667;
      5'd7:  v = 20'd7334;
      5'd8:  v = 20'd3667;
      5'd9:  v = 20'd1833;
      5'd10: v = 20'd917;
      5'd11: v = 20'd458;
      5'd12: v = 20'd229;
      5'd13: v = 20'd115;
      5'd14: v = 20'd57;
      5'd15: v = 20'd29;
      5'd16: v = 20'd14;
      5'd17: v = 20'd7;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      5'd20: v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/compass_heading_adaptive_filter.sv @@
// ----------------------------------------------------------------------------
// compass_heading_adaptive_filter
// Magnetometer compass heading with calibration and an adaptive EMA.
// ----------------------------------------------------------------------------
// Usage:
//   sample : X/Y raw counts plus a read-ok flag, valid/ready.
//   result : filtered heading in 1/64 degree plus a held flag, valid/ready.
//   cfg    : register writes (index, data); always ready, take effect at once.
//            Write only while no sample is in flight.
// Sequence:
//   A full update runs from the sample transfer to result_valid through the
//   calibration multiplies, squared-norm test, 16 shared CORDIC iterations,
//   then mount offset and the EMA multiply. A held result (failed read or a
//   near-zero vector) skips the CORDIC, mount offset and EMA steps.
//   One sample is worked at a time; sample_ready returns when the result is
//   loaded into the output register, so no new sample is taken before then.
// Stall:
//   The result sits in an output register; a new sample is taken while it
//   waits. If the next result is done first, the sequencer waits for it.
// Reset:
//   rst (sync, active high) loads register defaults, clears the filter to
//   heading 0 and unseeded, and empties the output register.
// ----------------------------------------------------------------------------
module compass_heading_adaptive_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  chaf_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_ready,
  output chaf_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import chaf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset     <= '0;
      cfg.y_offset     <= '0;
      cfg.x_scale      <= X_SCALE_RST;
      cfg.y_scale      <= Y_SCALE_RST;
      cfg.mount_angle  <= '0;
      cfg.alpha_fast   <= ALPHA_F_RST;
      cfg.alpha_medium <= ALPHA_M_RST;
      cfg.alpha_slow   <= ALPHA_S_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_OFFSET:     cfg.x_offset     <= $signed(cfg_data);
        CFG_Y_OFFSET:     cfg.y_offset     <= $signed(cfg_data);
        CFG_X_SCALE:      cfg.x_scale      <= cfg_data;
        CFG_Y_SCALE:      cfg.y_scale      <= cfg_data;
        CFG_MOUNT_ANGLE:  cfg.mount_angle  <= cfg_data[14:0];
        CFG_ALPHA_FAST:   cfg.alpha_fast   <= cfg_data;
        CFG_ALPHA_MEDIUM: cfg.alpha_medium <= cfg_data;
        CFG_ALPHA_SLOW:   cfg.alpha_slow   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  chaf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic and filter state; result register lives here
  chaf_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sample (sample),
    .cfg    (cfg),
    .status (status),
    .result (result)
  );

endmodule

@@ rtl/chaf_ctrl.sv @@
// ----------------------------------------------------------------------------
// chaf_ctrl
// Sequencer: steps the datapath through one sample and owns the handshakes.
// ----------------------------------------------------------------------------
module chaf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  chaf_pkg::status_t status,
  output chaf_pkg::cmd_t    cmd
);
  import chaf_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_MULX, S_MULY, S_SQX, S_SQY, S_TEST, S_DECIDE,
    S_CORDIC, S_MAP, S_MOUNT, S_DIFF, S_AMUL, S_UPDATE, S_OUT
  } state_t;

  state_t            state;
  logic [ITER_W-1:0] iter;
  logic              out_free;

  assign sample_ready = (state == S_IDLE);
  assign out_free     = !result_valid || result_ready;

  always_comb begin
    cmd.iter = iter;
    case (state)
      S_IDLE:   cmd.op = sample_valid ? OP_LOAD : OP_NOP;
      S_MULX:   cmd.op = OP_MULX;
      S_MULY:   cmd.op = OP_MULY;
      S_SQX:    cmd.op = OP_SQX;
      S_SQY:    cmd.op = OP_SQY;
      S_TEST:   cmd.op = OP_TEST;
      S_CORDIC: cmd.op = OP_STEP;
      S_MAP:    cmd.op = OP_MAP;
      S_MOUNT:  cmd.op = OP_MOUNT;
      S_DIFF:   cmd.op = OP_DIFF;
      S_AMUL:   cmd.op = OP_AMUL;
      S_UPDATE: cmd.op = OP_UPDATE;
      S_OUT:    cmd.op = out_free ? OP_OUT : OP_NOP;
      default:  cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iter         <= '0;
      result_valid <= 1'b0;
    end else begin
      // load a new result, or keep the current one until its transfer
      result_valid <= ((state == S_OUT) && out_free) || (result_valid && !result_ready);
      case (state)
        S_IDLE:   if (sample_valid) state <= S_MULX;
        S_MULX:   state <= S_MULY;
        S_MULY:   state <= S_SQX;
        S_SQX:    state <= S_SQY;
        S_SQY:    state <= S_TEST;
        S_TEST:   state <= S_DECIDE;
        S_DECIDE: begin
          iter  <= '0;
          state <= status.hold ? S_OUT : S_CORDIC;
        end
        S_CORDIC: begin
          iter <= iter + 1'b1;
          if (iter == ITER_W'(CORDIC_ITERS - 1)) state <= S_MAP;
        end
        S_MAP:    state <= S_MOUNT;
        S_MOUNT:  state <= S_DIFF;
        S_DIFF:   state <= S_AMUL;
        S_AMUL:   state <= S_UPDATE;
        S_UPDATE: state <= S_OUT;
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  `CHAF_ASSERT_NXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready,
    "sample accepted while a sample is in flight")
  `CHAF_ASSERT_IMP(a_out_only_when_free, cmd.op == OP_OUT, out_free,
    "result overwritten before transfer")
  `CHAF_ASSERT_NXT(a_cordic_starts_at_zero, state == S_DECIDE && !status.hold,
    cmd.op == OP_STEP && cmd.iter == '0, "CORDIC did not start at step zero")

endmodule

@@ rtl/chaf_datapath.sv @@
// ----------------------------------------------------------------------------
// chaf_datapath
// Calibration, norm test, iterative CORDIC, mount offset and adaptive EMA.
// ----------------------------------------------------------------------------
module chaf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  chaf_pkg::cmd_t    cmd,
  input  chaf_pkg::sample_t sample,
  input  chaf_pkg::cfg_t    cfg,
  output chaf_pkg::status_t status,
  output chaf_pkg::result_t result
);
  import chaf_pkg::*;
  `include "assert_macros.svh"

  // sample and calibration
  logic signed [16:0] dx, dy;
  logic               ok;
  logic               sx, sy;
  logic [31:0]        ux, uy;
  logic [39:0]        sqx, sqy;
  logic               bigx, bigy;
  logic               hold;
  // CORDIC
  logic signed [35:0] cx, cy;
  logic signed [22:0] z;
  // heading and filter
  logic [14:0]        h1, h2;
  logic signed [15:0] d;
  logic [16:0]        oma;
  logic signed [33:0] prod;
  logic [14:0]        fh;
  logic               seeded;

  // combinational helpers
  logic signed [33:0] mul_x, mul_y;
  logic [40:0]        sq_sum;
  logic signed [35:0] xs, ys;
  logic [22:0]        atan_v;
  logic [20:0]        zc;
  logic [22:0]        fine;
  logic [22:0]        rnd;
  logic [14:0]        mnt;
  logic [15:0]        mt;
  logic signed [16:0] dd, dw;
  logic [15:0]        ad;
  logic [15:0]        alpha;
  logic signed [33:0] stp_w;
  logic signed [16:0] nf;

  assign status.hold = hold;

  assign mul_x  = dx * $signed({1'b0, cfg.x_scale});
  assign mul_y  = dy * $signed({1'b0, cfg.y_scale});
  assign sq_sum = {1'b0, sqx} + {1'b0, sqy};
  assign xs     = cx >>> cmd.iter;
  assign ys     = cy >>> cmd.iter;
  assign atan_v = {3'b000, atan_lut(5'(cmd.iter))};

  always_comb begin
    // clamp to the first quadrant, then place in its quadrant
    if (z[22]) begin
      zc = '0;
    end else if (z[21:0] > 22'(QUARTER_FINE)) begin
      zc = 21'(QUARTER_FINE);
    end else begin
      zc = z[20:0];
    end
    case ({sx, sy})
      2'b00:   fine = {2'b00, zc};
      2'b10:   fine = 23'(2 * QUARTER_FINE) - {2'b00, zc};
      2'b11:   fine = 23'(2 * QUARTER_FINE) + {2'b00, zc};
      default: fine = 23'(4 * QUARTER_FINE) - {2'b00, zc};
    endcase
    rnd = (fine + 23'd128) >> 8;

    // mount offset, reduced once
    mnt = (cfg.mount_angle >= 15'(FULL_TURN)) ? cfg.mount_angle - 15'(FULL_TURN)
                                               : cfg.mount_angle;
    mt  = {1'b0, h1} + 16'(FULL_TURN) - {1'b0, mnt};

    // shortest signed difference
    dd = $signed({2'b00, h2}) - $signed({2'b00, fh});
    if (dd > 17'sd11520) begin
      dw = dd - 17'(FULL_TURN);
    end else if (dd < -17'sd11520) begin
      dw = dd + 17'(FULL_TURN);
    end else begin
      dw = dd;
    end
    ad = dw[16] ? 16'(-dw) : 16'(dw);
    if (ad > 16'(FAST_LIMIT)) begin
      alpha = cfg.alpha_fast;
    end else if (ad > 16'(MEDIUM_LIMIT)) begin
      alpha = cfg.alpha_medium;
    end else begin
      alpha = cfg.alpha_slow;
    end

    // rounded EMA step, then wrap
    stp_w = (prod + 34'sd32768) >>> 16;
    nf    = $signed({2'b00, fh}) + 17'(stp_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fh     <= '0;
      seeded <= 1'b0;
    end else if (cmd.op == OP_UPDATE) begin
      if (!seeded) begin
        fh     <= h2;
        seeded <= 1'b1;
      end else if (nf < 0) begin
        fh <= 15'(nf + 17'(FULL_TURN));
      end else if (nf >= 17'(FULL_TURN)) begin
        fh <= 15'(nf - 17'(FULL_TURN));
      end else begin
        fh <= 15'(nf);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dx <= 17'(sample.mag_x) - 17'(cfg.x_offset);
        dy <= 17'(sample.mag_y) - 17'(cfg.y_offset);
        ok <= sample.read_ok;
      end
      OP_MULX: begin
        sx <= mul_x[33];
        ux <= mul_x[33] ? 32'(-mul_x) : mul_x[31:0];
      end
      OP_MULY: begin
        sy <= mul_y[33];
        uy <= mul_y[33] ? 32'(-mul_y) : mul_y[31:0];
      end
      OP_SQX: begin
        sqx  <= ux[19:0] * ux[19:0];
        bigx <= |ux[31:20];
      end
      OP_SQY: begin
        sqy  <= uy[19:0] * uy[19:0];
        bigy <= |uy[31:20];
      end
      OP_TEST: begin
        hold <= !ok || (!(bigx || bigy) && (sq_sum < 41'(NEAR_LIMIT)));
        cx   <= $signed({4'b0000, ux});
        cy   <= $signed({4'b0000, uy});
        z    <= '0;
      end
      OP_STEP: begin
        if (!cy[35]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          z  <= z + $signed(atan_v);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          z  <= z - $signed(atan_v);
        end
      end
      OP_MAP:   h1 <= (rnd == 23'(FULL_TURN)) ? 15'd0 : rnd[14:0];
      OP_MOUNT: h2 <= (mt >= 16'(FULL_TURN)) ? 15'(mt - 16'(FULL_TURN)) : mt[14:0];
      OP_DIFF: begin
        d   <= 16'(dw);
        oma <= 17'h10000 - {1'b0, alpha};
      end
      OP_AMUL: prod <= $signed({1'b0, oma}) * d;
      OP_OUT: begin
        result.heading <= fh;
        result.held    <= hold;
      end
      default: ;
    endcase
  end

  `CHAF_ASSERT_IMP(a_fh_range, 1'b1, fh < 15'(FULL_TURN), "filtered heading out of range")
  `CHAF_ASSERT_NXT(a_h2_range, cmd.op == OP_MOUNT, h2 < 15'(FULL_TURN),
    "mounted heading out of range")
  `CHAF_ASSERT_NXT(a_seeded_after_update, cmd.op == OP_UPDATE, seeded,
    "filter not seeded after update")

endmodule

@@ sim/compass_heading_adaptive_filter_tb.sv @@
// ----------------------------------------------------------------------------
// compass_heading_adaptive_filter_tb
// Self-checking bench for the compass heading filter: drives magnetometer
// samples and register writes, predicts each filtered heading in-line and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module compass_heading_adaptive_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chaf_pkg::*;

  // Heading arithmetic, 1/64 degree for headings and 1/16384 degree in CORDIC
  localparam int     TURN          = 23040;
  localparam int     HALF          = 11520;
  localparam int     FAST_EDGE     = 320;
  localparam int     MEDIUM_EDGE   = 128;
  localparam longint QUADRANT      = 1474560;
  localparam int     ATAN_ENTRIES  = 24;
  localparam int     ROTATIONS     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  // Register indexes past the last defined one; writes there are dropped
  localparam logic [3:0] CFG_SPARE_FIRST = 4'd8;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 64;
  localparam int PHASE_ITEMS    = 130;
  localparam int RANDOM_PHASES  = 10;
  localparam int BURST_ITEMS    = 120;
  localparam real DEG_TO_RAD    = 3.14159265358979 / 180.0;

  logic        clk;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sample_t     sample;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  compass_heading_adaptive_filter u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // atan(2^-i) in 1/16384 degree, nearest
  longint atan_fine [0:ATAN_ENTRIES-1] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  // Mirror of the calibration registers
  logic signed [15:0] cal_x_offset;
  logic signed [15:0] cal_y_offset;
  logic [15:0]        cal_x_scale;
  logic [15:0]        cal_y_scale;
  logic [14:0]        cal_mount;
  logic [15:0]        cal_alpha_fast;
  logic [15:0]        cal_alpha_medium;
  logic [15:0]        cal_alpha_slow;

  // Mirror of the filter state
  int heading_state;
  bit heading_seeded;

  result_t heading_due[$];

  bit sender_idle_on;
  bit receiver_stall_on;
  int mismatch_count;
  int results_checked;
  int held_seen;
  int reg_writes;
  int settings_run;

  // Drift generator for slowly turning vectors
  real track_angle;
  real track_radius;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Heading predictor
  // --------------------------------------------------------------------------
  function automatic void reset_filter_mirror();
    cal_x_offset     = '0;
    cal_y_offset     = '0;
    cal_x_scale      = 16'd16384;
    cal_y_scale      = 16'd16384;
    cal_mount        = '0;
    cal_alpha_fast   = 16'd32768;
    cal_alpha_medium = 16'd49152;
    cal_alpha_slow   = 16'd58982;
    heading_state    = 0;
    heading_seeded   = 1'b0;
  endfunction

  function automatic void mirror_reg_write(input logic [3:0] idx, input logic [15:0] data);
    case (idx)
      CFG_X_OFFSET:     cal_x_offset     = data;
      CFG_Y_OFFSET:     cal_y_offset     = data;
      CFG_X_SCALE:      cal_x_scale      = data;
      CFG_Y_SCALE:      cal_y_scale      = data;
      CFG_MOUNT_ANGLE:  cal_mount        = data[14:0];
      CFG_ALPHA_FAST:   cal_alpha_fast   = data;
      CFG_ALPHA_MEDIUM: cal_alpha_medium = data;
      CFG_ALPHA_SLOW:   cal_alpha_slow   = data;
      default: ;  // spare index, no effect
    endcase
  endfunction

  // Works out the result of one sample and advances the filter mirror.
  function automatic result_t predict_heading(input sample_t s);
    longint  cx, cy, ux, uy;
    longint  vx, vy, z, xs, ys;
    longint  fine, h, d, alpha, step;
    bit      near_zero;
    result_t r;
    cx = (longint'(s.mag_x) - longint'(cal_x_offset)) * longint'(cal_x_scale);
    cy = (longint'(s.mag_y) - longint'(cal_y_offset)) * longint'(cal_y_scale);
    ux = (cx < 0) ? -cx : cx;
    uy = (cy < 0) ? -cy : cy;
    // norm below 1.1 counts after correction
    near_zero = (ux < (longint'(1) << 20)) && (uy < (longint'(1) << 20)) &&
                (100 * (ux * ux + uy * uy) < (longint'(121) << 28));
    if (!s.read_ok || near_zero) begin
      r.heading = 15'(heading_state);
      r.held    = 1'b1;
      return r;
    end
    // vectoring CORDIC on the first-quadrant vector
    vx = ux;
    vy = uy;
    z  = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx = vx + ys;
        vy = vy - xs;
        z  = z + atan_fine[i];
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        z  = z - atan_fine[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUADRANT) z = QUADRANT;
    if (cx >= 0 && cy >= 0)     fine = z;
    else if (cx < 0 && cy >= 0) fine = 2 * QUADRANT - z;
    else if (cx < 0)            fine = 2 * QUADRANT + z;
    else                        fine = 4 * QUADRANT - z;
    h = ((fine + 128) >>> 8) % TURN;
    h = (h + TURN - (longint'(cal_mount) % TURN)) % TURN;
    if (!heading_seeded) begin
      heading_state  = int'(h);
      heading_seeded = 1'b1;
    end else begin
      d = h - heading_state;
      if (d > HALF) d = d - TURN;
      else if (d < -HALF) d = d + TURN;
      if (d > FAST_EDGE || d < -FAST_EDGE)         alpha = longint'(cal_alpha_fast);
      else if (d > MEDIUM_EDGE || d < -MEDIUM_EDGE) alpha = longint'(cal_alpha_medium);
      else                                          alpha = longint'(cal_alpha_slow);
      step = ((65536 - alpha) * d + 32768) >>> 16;
      heading_state = int'((longint'(heading_state) + step + TURN) % TURN);
    end
    r.heading = 15'(heading_state);
    r.held    = 1'b0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sample side: one transfer per call, valid left high on return so a
  // back-to-back item keeps it high; wait_idle drops it.
  // --------------------------------------------------------------------------
  task automatic send_sample(input sample_t s);
    int gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      sample_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_valid = 1'b1;
    sample       = s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    heading_due.push_back(predict_heading(s));
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_idle();
    @(negedge clk);
    sample_valid = 1'b0;
    while (heading_due.size() != 0) @(posedge clk);
  endtask

  // Register write; caller makes sure no sample is in flight.
  task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror_reg_write(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_settings(input logic [15:0] xo, input logic [15:0] yo,
                                input logic [15:0] xs, input logic [15:0] ys,
                                input logic [15:0] mount, input logic [15:0] af,
                                input logic [15:0] am, input logic [15:0] as_);
    wait_idle();
    write_reg(CFG_X_OFFSET, xo);
    write_reg(CFG_Y_OFFSET, yo);
    write_reg(CFG_X_SCALE, xs);
    write_reg(CFG_Y_SCALE, ys);
    write_reg(CFG_MOUNT_ANGLE, mount);
    write_reg(CFG_ALPHA_FAST, af);
    write_reg(CFG_ALPHA_MEDIUM, am);
    write_reg(CFG_ALPHA_SLOW, as_);
    settings_run++;
  endtask

  function automatic sample_t make_sample(input logic [15:0] x, input logic [15:0] y,
                                          input logic ok);
    sample_t s;
    s.mag_x   = x;
    s.mag_y   = y;
    s.read_ok = ok;
    return s;
  endfunction

  function automatic logic [15:0] clamp_raw(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Random sample mix: mostly a slowly turning vector around the hard-iron
  // center so the filter spends time in all three alpha bands; the rest is
  // jumps, failed reads, near-zero vectors and raw noise.
  function automatic sample_t next_random_sample();
    sample_t s;
    int      kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      track_angle = track_angle + real'(int'($urandom_range(0, 1600)) - 800) / 100.0;
      if ($urandom_range(0, 15) == 0) track_radius = real'($urandom_range(20, 30000));
      s = make_sample(
        clamp_raw(longint'(cal_x_offset) + longint'(track_radius * $cos(track_angle * DEG_TO_RAD))),
        clamp_raw(longint'(cal_y_offset) + longint'(track_radius * $sin(track_angle * DEG_TO_RAD))),
        1'b1);
    end else if (kind < 72) begin
      track_angle = real'($urandom_range(0, 359));
      s = make_sample(16'($urandom), 16'($urandom), 1'b1);
    end else if (kind < 82) begin
      s = make_sample(16'($urandom), 16'($urandom), 1'b0);
    end else if (kind < 90) begin
      s = make_sample(clamp_raw(longint'(cal_x_offset) + int'($urandom_range(0, 2)) - 1),
                      clamp_raw(longint'(cal_y_offset) + int'($urandom_range(0, 2)) - 1),
                      1'b1);
    end else begin
      s = make_sample(16'($urandom), 16'($urandom), 1'($urandom));
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall bursts on result_ready
  // --------------------------------------------------------------------------
  initial begin
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (receiver_stall_on && $urandom_range(0, 9) == 0) begin
        result_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      result_ready = 1'b1;
      @(negedge clk);
    end
  end

  // Each result transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t due;
    if (!rst && result_valid && result_ready) begin
      if (heading_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none pending: heading %0d held %0b",
                 $time, result.heading, result.held);
      end else begin
        due = heading_due.pop_front();
        results_checked++;
        if (due.held) held_seen++;
        if (result.heading !== due.heading) begin
          mismatch_count++;
          $display("%0t: heading expected %0d actual %0d", $time, due.heading, result.heading);
        end
        if (result.held !== due.held) begin
          mismatch_count++;
          $display("%0t: held expected %0b actual %0b", $time, due.held, result.held);
        end
      end
    end
  end

  // Watchdog: too long without any transfer on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Before seeding: failed reads and near-zero vectors report heading 0.
  task automatic test_unseeded_hold();
    send_sample(make_sample(16'h7FFF, 16'h7FFF, 1'b0));
    send_sample(make_sample(16'h0000, 16'h0000, 1'b1));
    send_sample(make_sample(16'h0001, 16'h0000, 1'b1));
    send_sample(make_sample(16'hFFFF, 16'h0000, 1'b1));
    wait_idle();
  endtask

  // Seed on +X, then the other axes and three diagonals at full scale, the smallest
  // vector that passes the norm test, a hold after seeding, and small turns.
  task automatic test_axis_extremes();
    send_sample(make_sample(16'h7FFF, 16'h0000, 1'b1));
    send_sample(make_sample(16'h0000, 16'h7FFF, 1'b1));
    send_sample(make_sample(16'h8000, 16'h0000, 1'b1));
    send_sample(make_sample(16'h0000, 16'h8000, 1'b1));
    send_sample(make_sample(16'h8000, 16'h8000, 1'b1));
    send_sample(make_sample(16'h7FFF, 16'h8000, 1'b1));
    send_sample(make_sample(16'h8000, 16'h7FFF, 1'b1));
    send_sample(make_sample(16'h0001, 16'h0001, 1'b1));
    send_sample(make_sample(16'h1234, 16'h4321, 1'b0));
    send_sample(make_sample(16'd1000, 16'd10, 1'b1));
    send_sample(make_sample(16'd1000, 16'd40, 1'b1));
    send_sample(make_sample(16'd1000, 16'd60, 1'b1));
    wait_idle();
  endtask

  // Register extremes: largest offsets and scales, mount angle past a full
  // turn, zero and full alphas, zero scales, and writes to spare indexes.
  task automatic test_register_extremes();
    write_settings(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'h0000, 16'hFFFF, 16'h0000);
    write_reg(CFG_SPARE_FIRST, 16'hFFFF);
    write_reg(CFG_SPARE_FIRST + 4'd7, 16'h5A5A);
    send_sample(make_sample(16'h8000, 16'h7FFF, 1'b1));
    send_sample(make_sample(16'h7FFF, 16'h8000, 1'b1));
    send_sample(make_sample(16'h7FFF, 16'h8001, 1'b1));
    send_sample(make_sample(16'h0000, 16'h0000, 1'b1));
    write_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd23039,
                   16'hFFFF, 16'h0000, 16'hFFFF);
    send_sample(make_sample(16'h7FFF, 16'h7FFF, 1'b1));
    write_settings(16'h0000, 16'h0000, 16'd16384, 16'd16384, 16'd23040,
                   16'd32768, 16'd49152, 16'd58982);
    send_sample(make_sample(16'd2000, 16'd2000, 1'b1));
    send_sample(make_sample(16'd2000, 16'hF830, 1'b1));
    wait_idle();
  endtask

  function automatic logic [15:0] pick_offset();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return 16'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic [15:0] pick_scale();
    if ($urandom_range(0, 11) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(4096, 40000));
  endfunction

  function automatic logic [15:0] pick_alpha();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // Random settings per phase, a slowly turning field with noise mixed in.
  task automatic test_random_tracking();
    logic [15:0] mount;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       mount = 16'd0;
        1:       mount = 16'd23039;
        default: mount = 16'($urandom);
      endcase
      write_settings(pick_offset(), pick_offset(), pick_scale(), pick_scale(), mount,
                     pick_alpha(), pick_alpha(), pick_alpha());
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_SPARE_FIRST + 4'($urandom_range(0, 7)), 16'($urandom));
      track_radius = real'($urandom_range(50, 20000));
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(next_random_sample());
    end
    wait_idle();
  endtask

  // Closing burst with defaults and no idling on either side.
  task automatic test_back_to_back();
    write_settings(16'h0000, 16'h0000, 16'd16384, 16'd16384, 16'd0,
                   16'd32768, 16'd49152, 16'd58982);
    sender_idle_on    = 1'b0;
    receiver_stall_on = 1'b0;
    track_radius      = 3000.0;
    for (int n = 0; n < BURST_ITEMS; n++) send_sample(next_random_sample());
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    sample_valid      = 1'b0;
    sample            = '0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_X_OFFSET;
    cfg_data          = '0;
    sender_idle_on    = 1'b1;
    receiver_stall_on = 1'b1;
    mismatch_count    = 0;
    results_checked   = 0;
    held_seen         = 0;
    reg_writes        = 0;
    settings_run      = 0;
    track_angle       = 0.0;
    track_radius      = 1000.0;
    reset_filter_mirror();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_unseeded_hold();
    test_axis_extremes();
    test_register_extremes();
    test_random_tracking();
    test_back_to_back();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results (%0d held, %0d updated) over %0d register settings",
             results_checked, held_seen, results_checked - held_seen, settings_run);
    $display("Register writes: %0d, mismatches: %0d", reg_writes, mismatch_count);
    if (mismatch_count == 0 && heading_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
